// ----- hdl/apdc_pkg.sv -----
// ----------------------------------------------------------------------------
// apdc_pkg: shared types and constants for the deadband position controller
// Field widths, sequencer states, unit request/response structs and helpers.
// ----------------------------------------------------------------------------
package apdc_pkg;

  // Field widths
  localparam int unsigned ADC_W    = 10;  // potentiometer sample, limits
  localparam int unsigned TP_W     = 9;   // signed target percent
  localparam int unsigned PCT_W    = 7;   // clamped percent 0..100
  localparam int unsigned BAND_W   = 7;   // slow band / slow speed regs
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned DRV_W    = 2;
  localparam int unsigned T_W      = 17;  // target in ADC counts * 100
  localparam int unsigned N_W      = 18;  // 100 * (sample - lower), signed
  localparam int unsigned Q_W      = 19;  // relative target before clamping

  // Shared multiply-add unit
  localparam int unsigned MAC_A_W  = 18;
  localparam int unsigned MAC_B_W  = 9;
  localparam int unsigned MAC_R_W  = 24;

  // Iterative divider
  localparam int unsigned DIV_N_W  = 17;
  localparam int unsigned DIV_D_W  = 10;

  localparam int unsigned PCT_FULL     = 100;
  localparam int unsigned DUTY_FULL    = 255;
  // floor(x / 100) == (x * 41944) >> 22 for x below 32768
  localparam int unsigned DIV100_RECIP = 41944;
  localparam int unsigned DIV100_SHIFT = 22;

  localparam logic signed [DRV_W-1:0] DRV_STOP    = 2'sb00;
  localparam logic signed [DRV_W-1:0] DRV_EXTEND  = 2'sb01;
  localparam logic signed [DRV_W-1:0] DRV_RETRACT = 2'sb11;

  typedef enum logic [1:0] {
    CMD_ABS,
    CMD_REL,
    CMD_SAMPLE,
    CMD_RSVD
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_NO_LIMITS = 2'd1,
    ERR_LIMITS_EQ = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    REG_LOWER,
    REG_UPPER,
    REG_SLOW_BAND,
    REG_SLOW_SPEED
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_N_LO,
    ST_N_LAST,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_T_HI,
    ST_T_LO,
    ST_D_SPAN,
    ST_M_BAND,
    ST_DUTY,
    ST_S_LHS,
    ST_S_LOW,
    ST_S_HIGH,
    ST_S_DONE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                      en;
    logic signed [MAC_A_W-1:0] a;
    logic signed [MAC_B_W-1:0] b;
    logic signed [MAC_R_W-1:0] c;
  } mac_op_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quot;
    logic               rem_nz;
  } div_rsp_t;

  // floor(255 * pct / 100), saturated at full duty
  function automatic logic [DUTY_W-1:0] slow_duty(input logic [BAND_W-1:0] pct);
    logic [14:0] scaled;
    logic [30:0] prod;
    logic [8:0]  q;
    scaled = 15'(pct) * 15'(DUTY_FULL);
    prod   = 31'(scaled) * 31'(DIV100_RECIP);
    q      = 9'(prod >> DIV100_SHIFT);
    return (q > 9'(DUTY_FULL)) ? DUTY_W'(DUTY_FULL) : q[DUTY_W-1:0];
  endfunction

  function automatic logic [PCT_W-1:0] clamp_pct(input logic signed [Q_W-1:0] v);
    logic [PCT_W-1:0] r;
    if (v[Q_W-1]) begin
      r = '0;
    end else if (v > Q_W'(PCT_FULL)) begin
      r = PCT_W'(PCT_FULL);
    end else begin
      r = v[PCT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/apdc_mac.sv -----
// ----------------------------------------------------------------------------
// apdc_mac: shared multiply-add unit
// Registered r = a * b + c; loads only when the request is enabled.
// ----------------------------------------------------------------------------
module apdc_mac (
  input  logic                                    clk_i,
  input  apdc_pkg::mac_op_t                       op_i,
  output logic signed [apdc_pkg::MAC_R_W-1:0]     res_o
);

  logic signed [apdc_pkg::MAC_A_W+apdc_pkg::MAC_B_W-1:0] prod;
  logic signed [apdc_pkg::MAC_R_W-1:0]                   res_d;
  logic signed [apdc_pkg::MAC_R_W-1:0]                   res_q;

  assign prod  = op_i.a * op_i.b;
  assign res_d = $signed(prod[apdc_pkg::MAC_R_W-1:0]) + op_i.c;

  always_ff @(posedge clk_i) begin
    if (op_i.en) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- hdl/apdc_div.sv -----
// ----------------------------------------------------------------------------
// apdc_div: restoring divider, one quotient bit per cycle
// Unsigned magnitudes; done is high for a single cycle, along with the last step's result.
// ----------------------------------------------------------------------------
module apdc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  apdc_pkg::div_req_t  req_i,
  output apdc_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned CNT_W = $clog2(apdc_pkg::DIV_N_W + 1);

  logic [apdc_pkg::DIV_D_W-1:0] rem_q, rem_d, divisor_q;
  logic [apdc_pkg::DIV_N_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]             cnt_q;
  logic                         busy_q, done_q;
  logic [apdc_pkg::DIV_D_W:0]   trial, diff;
  logic                         fits;

  assign trial = {rem_q, quo_q[apdc_pkg::DIV_N_W-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign fits  = trial >= {1'b0, divisor_q};

  always_comb begin
    rem_d = fits ? diff[apdc_pkg::DIV_D_W-1:0] : trial[apdc_pkg::DIV_D_W-1:0];
    quo_d = {quo_q[apdc_pkg::DIV_N_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(apdc_pkg::DIV_N_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q     <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.quot   = quo_q;
  assign rsp_o.rem_nz = |rem_q;

endmodule

// ----- hdl/actuator_position_deadband_control.sv -----
// ----------------------------------------------------------------------------
// actuator_position_deadband_control: bang-bang actuator position loop
// Input stream: tuser = command (absolute target, relative target, sample),
// tdata = target percent and potentiometer sample. Output stream: one result
// per request with drive direction, PWM duty, reached flag and error code.
// The user writes the limits and slow-speed settings on the config channel only
// while idle; the block does not enforce this. A sequencer works each request
// around one shared multiply-add unit; relative targets also run a 17-step
// restoring divider. Accepted targets pass the multiply-add states; a sample
// that completes an average while moving runs the band compares; other samples
// and refused or unused commands go straight to the result. Input is ready again
// in the cycle after the result is loaded. The result sits in an output
// register; a new request can be accepted while it waits, and the next result
// holds in the sequencer until the register frees up. Reset clears limits,
// averaging state and target, and sets the slow speed to full duty.
// ----------------------------------------------------------------------------
module actuator_position_deadband_control #(
  parameter int unsigned AVG_SAMPLES = 4,   // 1..16
  parameter int unsigned DEADBAND    = 2    // 0..64 ADC counts
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [8:0] target_percent, [18:9] pot_sample
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [1:0] drive_direction, [9:2] pwm_duty,
                                      // [10] at_target, [12:11] error_code
);

  localparam int unsigned CNT_W = $clog2(AVG_SAMPLES + 1);
  localparam int unsigned SUM_W = apdc_pkg::ADC_W + $clog2(AVG_SAMPLES);
  // deadband edge offset, scaled like the sample sum (AVG * DB * 100)
  localparam logic signed [apdc_pkg::MAC_R_W-1:0] BAND_OFS =
    apdc_pkg::MAC_R_W'(AVG_SAMPLES * DEADBAND * apdc_pkg::PCT_FULL);

  // config registers
  logic [apdc_pkg::ADC_W-1:0]  lower_q, upper_q;
  logic [apdc_pkg::BAND_W-1:0] band_q, speed_q;
  logic [apdc_pkg::DUTY_W-1:0] slow_duty_q;

  // sequencer and scratch
  apdc_pkg::state_e                      state_q, state_d;
  apdc_pkg::cmd_e                        cmd_q, cmd_d;
  apdc_pkg::err_e                        err_q, err_d;
  logic signed [apdc_pkg::TP_W-1:0]      tp_q, tp_d;
  logic [apdc_pkg::PCT_W-1:0]            p_q, p_d;
  logic signed [apdc_pkg::N_W-1:0]       n_q, n_d;
  logic signed [apdc_pkg::MAC_R_W-1:0]   x_q, x_d;
  logic                                  lt_q, lt_d;

  // controller state
  logic [apdc_pkg::ADC_W-1:0]            last_q, last_d;
  logic [SUM_W-1:0]                      sum_q, sum_d;
  logic [CNT_W-1:0]                      cnt_q, cnt_d;
  logic [apdc_pkg::T_W-1:0]              target_q, target_d;
  logic [apdc_pkg::DUTY_W-1:0]           duty_q, duty_d;
  logic                                  moving_q, moving_d;
  logic                                  reached_q, reached_d;
  logic signed [apdc_pkg::DRV_W-1:0]     drive_q, drive_d;

  // output register
  logic                                  m_valid_q, m_valid_d;
  logic [15:0]                           m_data_q, m_data_d;

  // request fields
  apdc_pkg::cmd_e                        cmd_in;
  logic signed [apdc_pkg::TP_W-1:0]      tp_in;
  logic [apdc_pkg::ADC_W-1:0]            pot_in;
  logic                                  accept;

  // shared units
  apdc_pkg::mac_op_t                     mac_op;
  logic signed [apdc_pkg::MAC_R_W-1:0]   res;
  logic [apdc_pkg::MAC_R_W-1:0]          res_abs;
  apdc_pkg::div_req_t                    div_req;
  apdc_pkg::div_rsp_t                    div_rsp;

  // derived values
  logic signed [apdc_pkg::ADC_W:0]       span;
  logic                                  span_neg;
  logic [apdc_pkg::ADC_W-1:0]            abs_span;
  logic signed [apdc_pkg::DRV_W-1:0]     corr;
  logic                                  no_limits, limits_eq;
  logic [SUM_W-1:0]                      sum_nx;
  logic [CNT_W-1:0]                      cnt_nx;
  logic                                  avg_done;
  logic signed [apdc_pkg::Q_W-1:0]       q_pos, q_rel, tgt_rel;
  logic                                  q_neg;
  logic                                  out_load;
  logic [apdc_pkg::DUTY_W-1:0]           duty_out;

  assign cmd_in = apdc_pkg::cmd_e'(s_axis_tuser);
  assign tp_in  = $signed(s_axis_tdata[8:0]);
  assign pot_in = s_axis_tdata[18:9];
  assign accept = s_axis_tvalid && s_axis_tready;

  assign span      = $signed({1'b0, upper_q}) - $signed({1'b0, lower_q});
  assign span_neg  = lower_q > upper_q;
  assign abs_span  = span_neg ? (lower_q - upper_q) : (upper_q - lower_q);
  // drive toward the target: flipped when the limits are reversed
  assign corr      = span_neg ? apdc_pkg::DRV_RETRACT : apdc_pkg::DRV_EXTEND;
  assign no_limits = (lower_q == '0) && (upper_q == '0);
  assign limits_eq = lower_q == upper_q;

  assign sum_nx   = sum_q + SUM_W'(pot_in);
  assign cnt_nx   = cnt_q + CNT_W'(1);
  assign avg_done = cnt_nx >= CNT_W'(AVG_SAMPLES);

  assign res_abs = res[apdc_pkg::MAC_R_W-1] ? $unsigned(-res) : $unsigned(res);

  // floor division from magnitudes; res still holds 100*(last - lower)
  assign q_neg   = res[apdc_pkg::MAC_R_W-1] ^ span_neg;
  assign q_pos   = $signed(apdc_pkg::Q_W'(div_rsp.quot));
  assign q_rel   = q_neg ? (-q_pos - apdc_pkg::Q_W'(div_rsp.rem_nz)) : q_pos;
  assign tgt_rel = q_rel + apdc_pkg::Q_W'(tp_q);

  assign out_load = (state_q == apdc_pkg::ST_EMIT) && (!m_valid_q || m_axis_tready);
  assign duty_out = (drive_q == apdc_pkg::DRV_STOP) ? '0 : duty_q;

  assign s_axis_tready = state_q == apdc_pkg::ST_IDLE;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  apdc_mac u_mac (
    .clk_i (clk_i),
    .op_i  (mac_op),
    .res_o (res)
  );

  apdc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      apdc_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd_in)
            apdc_pkg::CMD_ABS: begin
              state_d = apdc_pkg::ST_N_LO;
            end
            apdc_pkg::CMD_REL: begin
              state_d = (no_limits || limits_eq) ? apdc_pkg::ST_EMIT : apdc_pkg::ST_N_LO;
            end
            apdc_pkg::CMD_SAMPLE: begin
              state_d = (avg_done && moving_q) ? apdc_pkg::ST_S_LHS : apdc_pkg::ST_EMIT;
            end
            apdc_pkg::CMD_RSVD: begin
              state_d = apdc_pkg::ST_EMIT;
            end
          endcase
        end
      end
      apdc_pkg::ST_N_LO:     state_d = apdc_pkg::ST_N_LAST;
      apdc_pkg::ST_N_LAST: begin
        state_d = (cmd_q == apdc_pkg::CMD_REL) ? apdc_pkg::ST_DIV_GO : apdc_pkg::ST_T_HI;
      end
      apdc_pkg::ST_DIV_GO:   state_d = apdc_pkg::ST_DIV_WAIT;
      apdc_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_d = apdc_pkg::ST_T_HI;
        end
      end
      apdc_pkg::ST_T_HI:     state_d = apdc_pkg::ST_T_LO;
      apdc_pkg::ST_T_LO:     state_d = apdc_pkg::ST_D_SPAN;
      apdc_pkg::ST_D_SPAN:   state_d = apdc_pkg::ST_M_BAND;
      apdc_pkg::ST_M_BAND:   state_d = apdc_pkg::ST_DUTY;
      apdc_pkg::ST_DUTY:     state_d = apdc_pkg::ST_EMIT;
      apdc_pkg::ST_S_LHS:    state_d = apdc_pkg::ST_S_LOW;
      apdc_pkg::ST_S_LOW:    state_d = apdc_pkg::ST_S_HIGH;
      apdc_pkg::ST_S_HIGH:   state_d = apdc_pkg::ST_S_DONE;
      apdc_pkg::ST_S_DONE:   state_d = apdc_pkg::ST_EMIT;
      apdc_pkg::ST_EMIT: begin
        if (out_load) begin
          state_d = apdc_pkg::ST_IDLE;
        end
      end
      default:               state_d = apdc_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Unit requests: one multiply-add per state
  // --------------------------------------------------------------------------
  always_comb begin
    mac_op = '0;
    unique case (state_q)
      apdc_pkg::ST_N_LO: begin     // -100 * lower
        mac_op.en = 1'b1;
        mac_op.a  = apdc_pkg::MAC_A_W'(lower_q);
        mac_op.b  = -$signed(apdc_pkg::MAC_B_W'(apdc_pkg::PCT_FULL));
      end
      apdc_pkg::ST_N_LAST: begin   // n = 100 * last - 100 * lower
        mac_op.en = 1'b1;
        mac_op.a  = apdc_pkg::MAC_A_W'(last_q);
        mac_op.b  = apdc_pkg::MAC_B_W'(apdc_pkg::PCT_FULL);
        mac_op.c  = res;
      end
      apdc_pkg::ST_T_HI: begin     // upper * p
        mac_op.en = 1'b1;
        mac_op.a  = apdc_pkg::MAC_A_W'(upper_q);
        mac_op.b  = apdc_pkg::MAC_B_W'(p_q);
      end
      apdc_pkg::ST_T_LO: begin     // + lower * (100 - p)
        mac_op.en = 1'b1;
        mac_op.a  = apdc_pkg::MAC_A_W'(lower_q);
        mac_op.b  = apdc_pkg::MAC_B_W'(apdc_pkg::PCT_FULL) - apdc_pkg::MAC_B_W'(p_q);
        mac_op.c  = res;
      end
      apdc_pkg::ST_D_SPAN: begin   // distance d = n - p * span
        mac_op.en = 1'b1;
        mac_op.a  = apdc_pkg::MAC_A_W'(span);
        mac_op.b  = -$signed(apdc_pkg::MAC_B_W'(p_q));
        mac_op.c  = apdc_pkg::MAC_R_W'(n_q);
      end
      apdc_pkg::ST_M_BAND: begin   // slow threshold (band + 1) * |span|
        mac_op.en = 1'b1;
        mac_op.a  = apdc_pkg::MAC_A_W'(abs_span);
        mac_op.b  = apdc_pkg::MAC_B_W'(band_q) + apdc_pkg::MAC_B_W'(1);
      end
      apdc_pkg::ST_S_LHS: begin    // sum * 100
        mac_op.en = 1'b1;
        mac_op.a  = apdc_pkg::MAC_A_W'(sum_q);
        mac_op.b  = apdc_pkg::MAC_B_W'(apdc_pkg::PCT_FULL);
      end
      apdc_pkg::ST_S_LOW: begin    // lower band edge
        mac_op.en = 1'b1;
        mac_op.a  = apdc_pkg::MAC_A_W'(target_q);
        mac_op.b  = apdc_pkg::MAC_B_W'(AVG_SAMPLES);
        mac_op.c  = -BAND_OFS;
      end
      apdc_pkg::ST_S_HIGH: begin   // upper band edge
        mac_op.en = 1'b1;
        mac_op.a  = apdc_pkg::MAC_A_W'(target_q);
        mac_op.b  = apdc_pkg::MAC_B_W'(AVG_SAMPLES);
        mac_op.c  = BAND_OFS;
      end
      default: begin
        mac_op = '0;
      end
    endcase
  end

  always_comb begin
    div_req.start    = state_q == apdc_pkg::ST_DIV_GO;
    div_req.dividend = res_abs[apdc_pkg::DIV_N_W-1:0];
    div_req.divisor  = abs_span;
  end

  // --------------------------------------------------------------------------
  // Datapath updates
  // --------------------------------------------------------------------------
  always_comb begin
    cmd_d     = cmd_q;
    err_d     = err_q;
    tp_d      = tp_q;
    p_d       = p_q;
    n_d       = n_q;
    x_d       = x_q;
    lt_d      = lt_q;
    last_d    = last_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    target_d  = target_q;
    duty_d    = duty_q;
    moving_d  = moving_q;
    reached_d = reached_q;
    drive_d   = drive_q;

    unique case (state_q)
      apdc_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_d = cmd_in;
          tp_d  = tp_in;
          err_d = apdc_pkg::ERR_OK;
          p_d   = apdc_pkg::clamp_pct(apdc_pkg::Q_W'(tp_in));
          unique case (cmd_in)
            apdc_pkg::CMD_REL: begin
              if (no_limits) begin
                err_d = apdc_pkg::ERR_NO_LIMITS;
              end else if (limits_eq) begin
                err_d = apdc_pkg::ERR_LIMITS_EQ;
              end
            end
            apdc_pkg::CMD_SAMPLE: begin
              last_d = pot_in;
              if (avg_done) begin
                cnt_d = '0;
                if (moving_q) begin
                  sum_d = sum_nx;   // compared in the following states
                end else begin
                  sum_d   = '0;
                  drive_d = apdc_pkg::DRV_STOP;
                end
              end else begin
                sum_d = sum_nx;
                cnt_d = cnt_nx;
              end
            end
            default: begin
            end
          endcase
        end
      end
      apdc_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          p_d = apdc_pkg::clamp_pct(tgt_rel);
        end
      end
      apdc_pkg::ST_T_HI: begin
        n_d = res[apdc_pkg::N_W-1:0];
      end
      apdc_pkg::ST_D_SPAN: begin
        target_d = res[apdc_pkg::T_W-1:0];
      end
      apdc_pkg::ST_M_BAND: begin
        x_d = $signed(res_abs);
      end
      apdc_pkg::ST_DUTY: begin
        // equal limits give a zero threshold, so full duty
        duty_d    = (x_q < res) ? slow_duty_q : apdc_pkg::DUTY_W'(apdc_pkg::DUTY_FULL);
        moving_d  = 1'b1;
        reached_d = 1'b0;
        drive_d   = apdc_pkg::DRV_STOP;
        sum_d     = '0;
        cnt_d     = '0;
      end
      apdc_pkg::ST_S_LOW: begin
        x_d = res;
      end
      apdc_pkg::ST_S_HIGH: begin
        lt_d = x_q < res;
      end
      apdc_pkg::ST_S_DONE: begin
        if (lt_q) begin
          drive_d = corr;
        end else if (x_q > res) begin
          drive_d = -corr;
        end else begin
          drive_d   = apdc_pkg::DRV_STOP;
          moving_d  = 1'b0;
          reached_d = 1'b1;
        end
        sum_d = '0;
        cnt_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (out_load) begin
      m_valid_d = 1'b1;
      m_data_d  = {3'b000, err_q, reached_q, duty_out, drive_q};
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= '0;
      band_q  <= '0;
      speed_q <= apdc_pkg::BAND_W'(apdc_pkg::PCT_FULL);
    end else if (cfg_valid_i) begin
      unique case (apdc_pkg::cfg_reg_e'(cfg_index_i))
        apdc_pkg::REG_LOWER:      lower_q <= cfg_data_i;
        apdc_pkg::REG_UPPER:      upper_q <= cfg_data_i;
        apdc_pkg::REG_SLOW_BAND:  band_q  <= cfg_data_i[apdc_pkg::BAND_W-1:0];
        apdc_pkg::REG_SLOW_SPEED: speed_q <= cfg_data_i[apdc_pkg::BAND_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= apdc_pkg::ST_IDLE;
      last_q    <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
      target_q  <= '0;
      duty_q    <= '0;
      moving_q  <= 1'b0;
      reached_q <= 1'b0;
      drive_q   <= apdc_pkg::DRV_STOP;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      last_q    <= last_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      target_q  <= target_d;
      duty_q    <= duty_d;
      moving_q  <= moving_d;
      reached_q <= reached_d;
      drive_q   <= drive_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    err_q       <= err_d;
    tp_q        <= tp_d;
    p_q         <= p_d;
    n_q         <= n_d;
    x_q         <= x_d;
    lt_q        <= lt_d;
    m_data_q    <= m_data_d;
    slow_duty_q <= apdc_pkg::slow_duty(speed_q);
  end

`ifndef SYNTHESIS
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == apdc_pkg::ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_drive_needs_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drive_q != apdc_pkg::DRV_STOP) |-> moving_q)
    else $error("motor driven with no move in progress");

  a_reached_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reached_q |-> !moving_q)
    else $error("reached flag set while still moving");

  a_drive_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_q == apdc_pkg::DRV_STOP || drive_q == apdc_pkg::DRV_EXTEND ||
    drive_q == apdc_pkg::DRV_RETRACT)
    else $error("illegal drive code");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == apdc_pkg::ST_EMIT))
    else $error("result raised outside the emit state");
`endif

endmodule

// ----- sim/apdc_drive_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// apdc_drive_checker: result checker for the deadband position controller
// Watches the config, request and result channels, keeps its own copy of
// the controller state, predicts one result per accepted request and
// compares every accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module apdc_drive_checker #(
  parameter int unsigned AVG_SAMPLES = 4,
  parameter int unsigned DEADBAND    = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [23:0] s_tdata_i,
  input  logic [1:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  import apdc_pkg::*;

  // packed to match result tdata[12:0]
  typedef struct packed {
    err_e                     err;
    logic                     reached;
    logic [DUTY_W-1:0]        duty;
    logic signed [DRV_W-1:0]  drive;
  } drive_result_t;

  // register copies
  logic [ADC_W-1:0]        lo_lim, up_lim;
  logic [BAND_W-1:0]       band_pct, speed_pct;
  // controller state copies
  logic [ADC_W-1:0]        last_adc;
  logic [13:0]             adc_sum;
  logic [4:0]              adc_cnt;
  logic [T_W-1:0]          aim_x100;
  logic [DUTY_W-1:0]       held_duty;
  logic                    moving, reached;
  logic signed [DRV_W-1:0] held_drive;

  drive_result_t expected_q[$];
  int mismatches = 0;
  int waiting    = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  task automatic note_mismatch(input string what, input longint seen, input longint want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, seen, want);
    mismatches++;
  endtask

  function automatic drive_result_t held_result(input err_e e);
    drive_result_t r;
    r.drive   = held_drive;
    r.duty    = (held_drive == DRV_STOP) ? '0 : held_duty;
    r.reached = reached;
    r.err     = e;
    return r;
  endfunction

  // New target: clamp, scale between the limits, pick the duty for the move.
  task automatic retarget(input longint p);
    longint lo, hi, span, gap, aspan;
    int unsigned slow;
    lo   = longint'(lo_lim);
    hi   = longint'(up_lim);
    span = hi - lo;
    if (p > longint'(PCT_FULL)) p = longint'(PCT_FULL);
    if (p < 0) p = 0;
    aim_x100 = T_W'(hi * p + lo * (PCT_FULL - p));
    if (span == 0) begin
      held_duty = DUTY_W'(DUTY_FULL);
    end else begin
      gap   = PCT_FULL * (longint'(last_adc) - lo) - p * span;
      gap   = (gap < 0) ? -gap : gap;
      aspan = (span < 0) ? -span : span;
      // distance in percent, truncated, at or below the slow band
      if (gap < (longint'(band_pct) + 1) * aspan) begin
        slow      = (DUTY_FULL * speed_pct) / PCT_FULL;
        held_duty = (slow > DUTY_FULL) ? DUTY_W'(DUTY_FULL) : DUTY_W'(slow);
      end else begin
        held_duty = DUTY_W'(DUTY_FULL);
      end
    end
    moving     = 1'b1;
    reached    = 1'b0;
    held_drive = DRV_STOP;
    adc_sum    = '0;
    adc_cnt    = '0;
  endtask

  task automatic take_request(input cmd_e c, input logic signed [TP_W-1:0] tp,
                              input logic [ADC_W-1:0] pot);
    longint n, q, span, lhs, t, band_lo, band_hi;
    logic signed [DRV_W-1:0] toward, away;
    drive_result_t r;
    // reversed limits flip the sense of the drive
    toward = (lo_lim > up_lim) ? DRV_RETRACT : DRV_EXTEND;
    away   = (lo_lim > up_lim) ? DRV_EXTEND : DRV_RETRACT;
    case (c)
      CMD_ABS: begin
        retarget(longint'(tp));
        r = held_result(ERR_OK);
      end
      CMD_REL: begin
        if (lo_lim == '0 && up_lim == '0) begin
          r = held_result(ERR_NO_LIMITS);
        end else if (lo_lim == up_lim) begin
          r = held_result(ERR_LIMITS_EQ);
        end else begin
          span = longint'(up_lim) - longint'(lo_lim);
          n    = PCT_FULL * (longint'(last_adc) - longint'(lo_lim));
          q    = n / span;
          // floor, not truncation
          if ((n % span) != 0 && ((n < 0) != (span < 0))) q--;
          retarget(q + longint'(tp));
          r = held_result(ERR_OK);
        end
      end
      CMD_SAMPLE: begin
        last_adc = pot;
        adc_sum  = adc_sum + pot;
        adc_cnt  = adc_cnt + 1'b1;
        if (adc_cnt >= AVG_SAMPLES) begin
          if (moving) begin
            lhs     = longint'(adc_sum) * PCT_FULL;
            t       = longint'(aim_x100);
            band_lo = longint'(AVG_SAMPLES) * (t - longint'(DEADBAND) * PCT_FULL);
            band_hi = longint'(AVG_SAMPLES) * (t + longint'(DEADBAND) * PCT_FULL);
            if (lhs < band_lo) begin
              held_drive = toward;
            end else if (lhs > band_hi) begin
              held_drive = away;
            end else begin
              held_drive = DRV_STOP;
              moving     = 1'b0;
              reached    = 1'b1;
            end
          end else begin
            held_drive = DRV_STOP;
          end
          adc_sum = '0;
          adc_cnt = '0;
        end
        r = held_result(ERR_OK);
      end
      default: r = held_result(ERR_OK);
    endcase
    expected_q.push_back(r);
  endtask

  task automatic check_result(input logic [15:0] data);
    drive_result_t seen, want;
    seen = drive_result_t'(data[12:0]);
    if (expected_q.size() == 0) begin
      note_mismatch("result with nothing outstanding", longint'(data), 0);
    end else begin
      want = expected_q.pop_front();
      if (seen.drive !== want.drive)
        note_mismatch("drive_direction", longint'(seen.drive), longint'(want.drive));
      if (seen.duty !== want.duty)
        note_mismatch("pwm_duty", longint'(seen.duty), longint'(want.duty));
      if (seen.reached !== want.reached)
        note_mismatch("at_target", longint'(seen.reached), longint'(want.reached));
      if (seen.err !== want.err)
        note_mismatch("error_code", longint'(seen.err), longint'(want.err));
      if (data[15:13] !== 3'b000)
        note_mismatch("tdata padding", longint'(data[15:13]), 0);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_lim     = '0;
      up_lim     = '0;
      band_pct   = '0;
      speed_pct  = BAND_W'(PCT_FULL);
      last_adc   = '0;
      adc_sum    = '0;
      adc_cnt    = '0;
      aim_x100   = '0;
      held_duty  = '0;
      moving     = 1'b0;
      reached    = 1'b0;
      held_drive = DRV_STOP;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_LOWER:      lo_lim    = cfg_data_i[ADC_W-1:0];
          REG_UPPER:      up_lim    = cfg_data_i[ADC_W-1:0];
          REG_SLOW_BAND:  band_pct  = cfg_data_i[BAND_W-1:0];
          REG_SLOW_SPEED: speed_pct = cfg_data_i[BAND_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        take_request(cmd_e'(s_tuser_i), s_tdata_i[8:0], s_tdata_i[18:9]);
      if (m_tvalid_i && m_tready_i)
        check_result(m_tdata_i);
    end
    waiting = expected_q.size();
  end

endmodule

// ----- sim/tb_actuator_position_deadband_control.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_actuator_position_deadband_control: testbench for the deadband loop
// Drives a directed sequence and then random target/sample traffic under
// several limit and slow-speed settings, with random idle and stall on both
// streams. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_actuator_position_deadband_control;
  import apdc_pkg::*;

  localparam int unsigned AVG_N     = 4;
  localparam int unsigned DB_COUNTS = 2;
  localparam int SEGMENTS    = 9;      // three settings per idle pattern
  localparam int SEG_ITEMS   = 60;
  localparam int TAIL_CYCLES = 40;
  localparam int LIMIT_NS    = 1_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  int fail_count;
  int pending;

  // idle pattern, in percent of cycles
  int send_idle_pct  = 6;
  int recv_stall_pct = 74;

  // rough copy of where the block is heading, only to steer samples
  int lo_set   = 0;
  int up_set   = 0;
  int aim_adc  = 0;
  int last_pot = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  actuator_position_deadband_control #(
    .AVG_SAMPLES (AVG_N),
    .DEADBAND    (DB_COUNTS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  apdc_drive_checker #(
    .AVG_SAMPLES (AVG_N),
    .DEADBAND    (DB_COUNTS)
  ) u_drive_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Result side backpressure, redrawn every cycle.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // ADC value that a target percent maps to under the current limits
  function automatic int adc_at(input int p);
    if (p > 100) p = 100;
    if (p < 0) p = 0;
    return (up_set * p + lo_set * (100 - p)) / 100;
  endfunction

  // One request. Entered right after the previous accept edge (or any time
  // for the first one); valid stays high into the next request unless the
  // sender decides to idle.
  task automatic send_req(input cmd_e c, input int tp, input int pot);
    int span;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {5'b0, 10'(pot), 9'(tp)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // track the target for steering only
    span = up_set - lo_set;
    case (c)
      CMD_ABS:    aim_adc = adc_at(int'($signed(9'(tp))));
      CMD_REL:    if (span != 0)
                    aim_adc = adc_at(100 * (last_pot - lo_set) / span + int'($signed(9'(tp))));
      CMD_SAMPLE: last_pot = pot;
      default: ;
    endcase
  endtask

  // one register write; entered and left at a falling edge
  task automatic cfg_put(input cfg_reg_e idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 10'(val);
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Settings change only with the block drained: every result back.
  task automatic write_settings(input int lo, input int up, input int band, input int speed);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_put(REG_LOWER, lo);
    cfg_put(REG_UPPER, up);
    cfg_put(REG_SLOW_BAND, band);
    cfg_put(REG_SLOW_SPEED, speed);
    cfg_valid <= 1'b0;
    lo_set = lo;
    up_set = up;
  endtask

  initial begin
    int lo, up, band, speed, pick, tp, pot;
    rst_ni        = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_LOWER;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_ABS;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed ---
    // reset settings: no limits set
    send_req(CMD_RSVD, 37, 512);        // unused code reports held outputs
    send_req(CMD_REL, 10, 0);           // refused: no limits
    send_req(CMD_ABS, 255, 1023);       // clamps high, equal limits: full duty
    send_req(CMD_SAMPLE, -256, 1023);   // samples during the move
    send_req(CMD_SAMPLE, 255, 0);

    // normal travel 200..800, slow band 20 %, slow speed 40 %
    write_settings(200, 800, 20, 40);
    send_req(CMD_ABS, 50, 0);           // far move, full duty
    repeat (4) send_req(CMD_SAMPLE, 0, 500);   // average on target: reached
    send_req(CMD_REL, 5, 0);            // short move, reduced duty
    repeat (4) send_req(CMD_SAMPLE, 0, 200);   // below band: extend

    // equal nonzero limits
    write_settings(500, 500, 0, 100);
    send_req(CMD_REL, -3, 0);           // refused: limits equal
    send_req(CMD_ABS, 0, 0);            // accepted, target at the limit

    // reversed limits, widest band
    write_settings(1023, 0, 100, 100);
    send_req(CMD_ABS, 50, 0);
    repeat (4) send_req(CMD_SAMPLE, 0, 0);     // drive inverted

    // --- random ---
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 3)
        0:       begin send_idle_pct = 6;  recv_stall_pct = 74; end
        1:       begin send_idle_pct = 74; recv_stall_pct = 6;  end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      case (seg)
        0: begin lo = 100;  up = 900; band = 10;  speed = 50;  end
        1: begin lo = 1023; up = 0;   band = 100; speed = 0;   end
        2: begin lo = 500;  up = 500; band = 0;   speed = 100; end
        3: begin lo = 0;    up = 1023; band = 5;  speed = 73;  end
        5: begin
          lo    = $urandom_range(512, 1023);
          up    = $urandom_range(0, 511);
          band  = $urandom_range(0, 100);
          speed = $urandom_range(0, 100);
        end
        6: begin lo = 0;    up = 0;    band = 50;  speed = 25;  end
        8: begin lo = 0;    up = 1023; band = 100; speed = 100; end
        default: begin
          lo    = $urandom_range(0, 1023);
          up    = $urandom_range(0, 1023);
          band  = $urandom_range(0, 100);
          speed = $urandom_range(0, 100);
        end
      endcase
      write_settings(lo, up, band, speed);

      for (int i = 0; i < SEG_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
          // absolute target, mostly in range
          if ($urandom_range(0, 3) == 0) tp = int'($urandom_range(0, 511)) - 256;
          else                           tp = $urandom_range(0, 100);
          send_req(CMD_ABS, tp, $urandom_range(0, 1023));
        end else if (pick < 24) begin
          // relative target, mostly small steps
          if ($urandom_range(0, 4) == 0) tp = int'($urandom_range(0, 511)) - 256;
          else                           tp = int'($urandom_range(0, 60)) - 30;
          send_req(CMD_REL, tp, $urandom_range(0, 1023));
        end else if (pick < 97) begin
          // samples: mostly close to the target so averages land in the band
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: pot = aim_adc + int'($urandom_range(0, 8)) - 4;
            6, 7:             pot = $urandom_range(0, 1023);
            8:                pot = $urandom_range(0, 1) ? 1023 : 0;
            default:          pot = aim_adc + int'($urandom_range(0, 40)) - 20;
          endcase
          if (pot < 0) pot = 0;
          if (pot > 1023) pot = 1023;
          send_req(CMD_SAMPLE, int'($urandom_range(0, 511)) - 256, pot);
        end else begin
          send_req(CMD_RSVD, int'($urandom_range(0, 511)) - 256, $urandom_range(0, 1023));
        end
      end
    end

    // --- drain and verdict ---
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/apdc_pkg.sv
hdl/apdc_mac.sv
hdl/apdc_div.sv
hdl/actuator_position_deadband_control.sv
sim/apdc_drive_checker.sv
sim/tb_actuator_position_deadband_control.sv
